[sv/lobm_pkg.sv]
// Shared codes and the record type that travels down the cell chain.
// Used by lobm_cell and limit_order_book_matcher; depends on nothing.
package lobm_pkg;

  // request codes on req_type
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // pass operations
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_UPD    = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_PENDING = 3'd1;
  localparam logic [2:0] ST_PARTIAL = 3'd2;
  localparam logic [2:0] ST_FILLED  = 3'd3;
  localparam logic [2:0] ST_REJECT  = 3'd4;

  typedef struct packed {
    logic        v;
    logic [15:0] price;
    logic [31:0] id;
    logic [15:0] qty;
    logic [15:0] filled;
    logic [23:0] avg;
  } lobm_best_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;       // new id for add, target id for cancel/query
    logic [15:0] qty;
    logic [15:0] price;
    logic        sell;
    logic        mkt;
    logic        b_en;      // update of the resting order at cmd_idx
    logic [15:0] b_filled;
    logic [23:0] b_avg;
    logic [15:0] n_filled;  // update of the incoming order
    logic [23:0] n_avg;
    logic        n_rest;
    logic        n_last;
    logic        hit;       // free slot claimed or id found
    logic [15:0] hit_filled;
    logic [15:0] hit_qty;
    logic [23:0] hit_avg;
    logic        hit_rest;
    logic        hit_sell;
    lobm_best_t  bid;
    lobm_best_t  ask;
  } lobm_rec_t;

endpackage

[sv/lobm_cell.sv]
// One order slot of the book; acts on the passing record and forwards it.
// Depends on lobm_pkg.
module lobm_cell #(
  parameter int unsigned IW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  lobm_pkg::lobm_rec_t rec_i,
  input  logic [IW-1:0]       cmd_idx_i,
  input  logic [IW-1:0]       bid_idx_i,
  input  logic [IW-1:0]       ask_idx_i,
  output logic                vld_o,
  output lobm_pkg::lobm_rec_t rec_o,
  output logic [IW-1:0]       cmd_idx_o,
  output logic [IW-1:0]       bid_idx_o,
  output logic [IW-1:0]       ask_idx_o
);
  import lobm_pkg::*;

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic valid_q, valid_d, rest_q, rest_d, newb_q, newb_d;
  logic sell_q, sell_d, mkt_q, mkt_d;
  logic [31:0] id_q, id_d;
  logic [15:0] qty_q, qty_d, filled_q, filled_d, price_q, price_d;
  logic [23:0] avg_q, avg_d;

  logic vld_q;
  lobm_rec_t rec_q, rec_d;
  logic [IW-1:0] cidx_q, bidx_q, bidx_d, aidx_q, aidx_d;
  logic id_hit, erase;

  always_comb begin
    valid_d = valid_q; rest_d = rest_q; newb_d = newb_q;
    sell_d = sell_q; mkt_d = mkt_q; id_d = id_q; qty_d = qty_q;
    filled_d = filled_q; price_d = price_q; avg_d = avg_q;
    rec_d  = rec_i;
    bidx_d = bid_idx_i;
    aidx_d = ask_idx_i;
    id_hit = !rec_i.hit && valid_q && (id_q == rec_i.key);
    erase  = (filled_q != 16'd0) && ((filled_q >= qty_q) || mkt_q);
    if (vld_i) begin
      case (rec_i.op)
        OP_ADD: begin
          if (!rec_i.hit && !valid_q) begin
            valid_d = 1'b1; rest_d = 1'b0; newb_d = 1'b1;
            sell_d = rec_i.sell; mkt_d = rec_i.mkt; id_d = rec_i.key;
            qty_d = rec_i.qty; filled_d = 16'd0; price_d = rec_i.price;
            avg_d = 24'd0;
            rec_d.hit = 1'b1;
          end
        end
        OP_UPD: begin
          if (rec_i.b_en && (cmd_idx_i == MyIdx)) begin
            filled_d = rec_i.b_filled;
            avg_d    = rec_i.b_avg;
            if (rec_i.b_filled >= qty_q) rest_d = 1'b0;
          end
          if (newb_q) begin
            filled_d = rec_i.n_filled;
            avg_d    = rec_i.n_avg;
            rest_d   = rec_i.n_rest;
            if (rec_i.n_last) newb_d = 1'b0;
          end
        end
        OP_CANCEL, OP_QUERY: begin
          if (id_hit) begin
            rec_d.hit        = 1'b1;
            rec_d.hit_filled = filled_q;
            rec_d.hit_qty    = qty_q;
            rec_d.hit_avg    = avg_q;
            rec_d.hit_rest   = rest_q;
            rec_d.hit_sell   = sell_q;
            if ((rec_i.op == OP_CANCEL) ? rest_q : erase) begin
              valid_d = 1'b0; rest_d = 1'b0;
            end
          end
        end
        OP_CLEAR: begin
          valid_d = 1'b0; rest_d = 1'b0; newb_d = 1'b0;
        end
        default: ;
      endcase
      // best price accumulation on post-update contents
      if (rest_d && sell_d) begin
        if (!rec_i.ask.v || (price_d < rec_i.ask.price) ||
            ((price_d == rec_i.ask.price) && (id_d < rec_i.ask.id))) begin
          rec_d.ask = '{v: 1'b1, price: price_d, id: id_d, qty: qty_d,
                        filled: filled_d, avg: avg_d};
          aidx_d = MyIdx;
        end
      end else if (rest_d) begin
        if (!rec_i.bid.v || (price_d > rec_i.bid.price) ||
            ((price_d == rec_i.bid.price) && (id_d < rec_i.bid.id))) begin
          rec_d.bid = '{v: 1'b1, price: price_d, id: id_d, qty: qty_d,
                        filled: filled_d, avg: avg_d};
          bidx_d = MyIdx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0; rest_q <= 1'b0; newb_q <= 1'b0; vld_q <= 1'b0;
    end else begin
      valid_q <= valid_d; rest_q <= rest_d; newb_q <= newb_d; vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sell_q <= sell_d; mkt_q <= mkt_d; id_q <= id_d; qty_q <= qty_d;
    filled_q <= filled_d; price_q <= price_d; avg_q <= avg_d;
    rec_q <= rec_d; cidx_q <= cmd_idx_i; bidx_q <= bidx_d; aidx_q <= aidx_d;
  end

  assign vld_o     = vld_q;
  assign rec_o     = rec_q;
  assign cmd_idx_o = cidx_q;
  assign bid_idx_o = bidx_q;
  assign ask_idx_o = aidx_q;

endmodule

[sv/lobm_div.sv]
// Restoring divider for average prices, one quotient bit per cycle.
// Quotient must fit 24 bits. Depends on nothing.
module lobm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [40:0] num_i,
  input  logic [16:0] den_i,
  output logic        done_o,
  output logic [23:0] quo_o
);
  logic [16:0] rem_q, rem_d, den_q;
  logic [23:0] sh_q, sh_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    rem_d = rem_q; sh_d = sh_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, sh_q[23]};
    if (start_i) begin
      rem_d = num_i[40:24]; sh_d = num_i[23:0]; cnt_d = 5'd24; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 17'(trial - {1'b0, den_q});
        sh_d  = {sh_q[22:0], 1'b1};
      end else begin
        rem_d = trial[16:0];
        sh_d  = {sh_q[22:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= 5'd0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; sh_q <= sh_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

[sv/limit_order_book_matcher.sv]
// Top level: request sequencer, fill arithmetic and the chain of order cells.
// Depends on lobm_pkg, lobm_cell, lobm_div.
//
// channel  | direction | handshake               | carries
// ---------+-----------+-------------------------+------------------------------
// in       | input     | in_valid_i / in_ready_o | one request item
// out      | output    | out_valid_o/out_ready_i | one result item per request
// cfg      | input     | cfg_valid_i/cfg_ready_o | last price preset, loads last price
//
// Every request runs a pass of a record down the cell chain: the launch
// register, then each cell. Cancel, query and clear take one pass; the item
// after is taken once the result is registered. An add takes (k+2) passes for
// k fills, or one if no slot is free: per fill two runs of the shared divider
// with setup, then an update pass.
// Reset clears slot valid bits at once; no clearing pass is needed.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken, and a held output stalls the input.
module limit_order_book_matcher #(
  parameter int unsigned MAX_ORDERS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] quantity_i,
  input  logic        side_sell_i,
  input  logic        is_market_i,
  input  logic [15:0] limit_price_i,
  input  logic [31:0] target_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] order_id_o,
  output logic [2:0]  status_o,
  output logic [15:0] filled_qty_o,
  output logic [23:0] avg_price_o,
  output logic [15:0] last_price_o,
  output logic [15:0] best_bid_o,
  output logic [15:0] best_ask_o,
  output logic [23:0] bid_volume_o,
  output logic [23:0] ask_volume_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import lobm_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ORDERS);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WAIT   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DLOAD  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  // add phases
  localparam logic [1:0] PH_CLAIM = 2'd0;
  localparam logic [1:0] PH_LOOP  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  // chain wiring, index 0 is the launch register
  logic          c_vld [MAX_ORDERS+1];
  lobm_rec_t     c_rec [MAX_ORDERS+1];
  logic [IW-1:0] c_cidx[MAX_ORDERS+1];
  logic [IW-1:0] c_bidx[MAX_ORDERS+1];
  logic [IW-1:0] c_aidx[MAX_ORDERS+1];

  logic state_vld_unused;
  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d, req_q, req_d;
  logic sell_q, sell_d, mkt_q, mkt_d, sel_q, sel_d;
  logic [15:0] nqty_q, nqty_d, lim_q, lim_d, nfill_q, nfill_d;
  logic [31:0] key_q, key_d, next_id_q, next_id_d;
  logic [23:0] navg_q, navg_d, navgn_q, navgn_d;
  logic [15:0] fill_q, fill_d, p_q, p_d, bf_q, bf_d;
  logic [23:0] ba_q, ba_d;
  logic [IW-1:0] bidx_q, bidx_d;
  logic [39:0] mula_q, mula_d;
  logic [31:0] mulb_q, mulb_d;
  logic [16:0] den_q, den_d;
  logic [15:0] trade_q, trade_d;
  logic [23:0] bvol_q, bvol_d, svol_q, svol_d;
  lobm_rec_t tail_q, tail_d;
  logic [IW-1:0] tbidx_q, tbidx_d, taidx_q, taidx_d;
  logic [31:0] roid_q, roid_d;
  logic [2:0]  rst_q, rst_d;
  logic [15:0] rfq_q, rfq_d;
  logic [23:0] rav_q, rav_d;

  logic l_vld_q, l_vld_d;
  lobm_rec_t l_rec_q, l_rec_d;
  logic [IW-1:0] l_idx_q, l_idx_d;

  logic out_valid_q, out_valid_d;
  logic [31:0] o_oid_q, o_oid_d;
  logic [2:0]  o_st_q, o_st_d;
  logic [15:0] o_fq_q, o_fq_d, o_lp_q, o_lp_d, o_bb_q, o_bb_d, o_ba_q, o_ba_d;
  logic [23:0] o_av_q, o_av_d, o_bv_q, o_bv_d, o_sv_q, o_sv_d;

  logic div_start, div_done;
  logic [23:0] div_quo;
  logic [40:0] div_num;

  lobm_best_t opp;
  logic [IW-1:0] opp_idx;
  logic [15:0] rn, rb, mf, rem;
  logic [23:0] ma;
  logic price_ok;

  assign c_vld[0]  = l_vld_q;
  assign c_rec[0]  = l_rec_q;
  assign c_cidx[0] = l_idx_q;
  assign c_bidx[0] = '0;
  assign c_aidx[0] = '0;

  for (genvar g = 0; g < MAX_ORDERS; g++) begin : g_cell
    lobm_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .vld_i     (c_vld[g]),
      .rec_i     (c_rec[g]),
      .cmd_idx_i (c_cidx[g]),
      .bid_idx_i (c_bidx[g]),
      .ask_idx_i (c_aidx[g]),
      .vld_o     (c_vld[g+1]),
      .rec_o     (c_rec[g+1]),
      .cmd_idx_o (c_cidx[g+1]),
      .bid_idx_o (c_bidx[g+1]),
      .ask_idx_o (c_aidx[g+1])
    );
  end

  lobm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign div_num = {1'b0, mula_q} + {1'b0, mulb_q, 8'd0};
  assign state_vld_unused = c_vld[MAX_ORDERS];

  always_comb begin
    state_d = state_q; phase_d = phase_q; req_d = req_q;
    sell_d = sell_q; mkt_d = mkt_q; sel_d = sel_q;
    nqty_d = nqty_q; lim_d = lim_q; nfill_d = nfill_q; key_d = key_q;
    next_id_d = next_id_q; navg_d = navg_q; navgn_d = navgn_q;
    fill_d = fill_q; p_d = p_q; bf_d = bf_q; ba_d = ba_q; bidx_d = bidx_q;
    mula_d = mula_q; mulb_d = mulb_q; den_d = den_q;
    trade_d = trade_q; bvol_d = bvol_q; svol_d = svol_q;
    tail_d = tail_q; tbidx_d = tbidx_q; taidx_d = taidx_q;
    roid_d = roid_q; rst_d = rst_q; rfq_d = rfq_q; rav_d = rav_q;
    l_vld_d = 1'b0; l_rec_d = l_rec_q; l_idx_d = l_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_oid_d = o_oid_q; o_st_d = o_st_q; o_fq_d = o_fq_q; o_av_d = o_av_q;
    o_lp_d = o_lp_q; o_bb_d = o_bb_q; o_ba_d = o_ba_q;
    o_bv_d = o_bv_q; o_sv_d = o_sv_q;
    div_start = 1'b0;

    // opposite side of the incoming order: buys meet asks
    opp     = sell_q ? tail_q.bid : tail_q.ask;
    opp_idx = sell_q ? tbidx_q : taidx_q;
    rn      = nqty_q - nfill_q;
    rb      = opp.qty - opp.filled;
    rem     = nqty_q - nfill_q;
    price_ok = mkt_q || (sell_q ? (opp.price >= lim_q) : (opp.price <= lim_q));
    mf      = sel_q ? bf_q : nfill_q;
    ma      = sel_q ? ba_q : navg_q;

    if (cfg_valid_i) trade_d = cfg_data_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = req_type_i; sell_d = side_sell_i; mkt_d = is_market_i;
          nqty_d = quantity_i; lim_d = limit_price_i; phase_d = PH_CLAIM;
          l_rec_d = '0;
          l_rec_d.qty = quantity_i; l_rec_d.price = limit_price_i;
          l_rec_d.sell = side_sell_i; l_rec_d.mkt = is_market_i;
          l_idx_d = '0;
          case (req_type_i)
            REQ_ADD:    begin l_rec_d.op = OP_ADD; key_d = next_id_q; end
            REQ_CANCEL: begin l_rec_d.op = OP_CANCEL; key_d = target_id_i; end
            REQ_QUERY:  begin l_rec_d.op = OP_QUERY; key_d = target_id_i; end
            default:    begin l_rec_d.op = OP_CLEAR; key_d = target_id_i; end
          endcase
          l_rec_d.key = (req_type_i == REQ_ADD) ? next_id_q : target_id_i;
          l_vld_d = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (c_vld[MAX_ORDERS]) begin
          tail_d  = c_rec[MAX_ORDERS];
          tbidx_d = c_bidx[MAX_ORDERS];
          taidx_d = c_aidx[MAX_ORDERS];
          roid_d = key_q; rst_d = ST_NONE; rfq_d = 16'd0; rav_d = 24'd0;
          state_d = S_RESULT;
          case (req_q)
            REQ_ADD: begin
              if (phase_q == PH_CLAIM) begin
                if (!c_rec[MAX_ORDERS].hit) begin
                  roid_d = 32'd0; rst_d = ST_REJECT;
                end else begin
                  next_id_d = next_id_q + 32'd1;
                  nfill_d = 16'd0; navg_d = 24'd0;
                  state_d = S_EVAL;
                end
              end else if (phase_q == PH_LOOP) begin
                state_d = S_EVAL;
              end else begin
                if (nfill_q == 16'd0) begin
                  rst_d = ST_PENDING;
                end else begin
                  rst_d = (nfill_q < nqty_q) ? ST_PARTIAL : ST_FILLED;
                  rfq_d = nfill_q; rav_d = navg_q;
                end
              end
            end
            REQ_CANCEL: begin
              if (c_rec[MAX_ORDERS].hit && c_rec[MAX_ORDERS].hit_rest) begin
                if (c_rec[MAX_ORDERS].hit_sell)
                  svol_d = svol_q - {8'd0, 16'(c_rec[MAX_ORDERS].hit_qty -
                                              c_rec[MAX_ORDERS].hit_filled)};
                else
                  bvol_d = bvol_q - {8'd0, 16'(c_rec[MAX_ORDERS].hit_qty -
                                              c_rec[MAX_ORDERS].hit_filled)};
              end
            end
            REQ_QUERY: begin
              if (c_rec[MAX_ORDERS].hit) begin
                if (c_rec[MAX_ORDERS].hit_filled == 16'd0) begin
                  rst_d = ST_PENDING;
                end else begin
                  rst_d = (c_rec[MAX_ORDERS].hit_filled < c_rec[MAX_ORDERS].hit_qty)
                          ? ST_PARTIAL : ST_FILLED;
                  rfq_d = c_rec[MAX_ORDERS].hit_filled;
                  rav_d = c_rec[MAX_ORDERS].hit_avg;
                end
              end
            end
            default: begin
              bvol_d = 24'd0; svol_d = 24'd0; next_id_d = 32'd1;
            end
          endcase
        end
      end
      S_EVAL: begin
        l_rec_d = '0;
        l_rec_d.op = OP_UPD;
        if ((nfill_q < nqty_q) && opp.v && price_ok) begin
          fill_d = (rn < rb) ? rn : rb;
          p_d = opp.price; bf_d = opp.filled; ba_d = opp.avg; bidx_d = opp_idx;
          sel_d = 1'b0;
          state_d = S_MUL;
        end else begin
          // no more liquidity in range: rest the remainder if a limit order
          l_rec_d.n_filled = nfill_q; l_rec_d.n_avg = navg_q; l_rec_d.n_last = 1'b1;
          if (!mkt_q && (nfill_q < nqty_q)) begin
            l_rec_d.n_rest = 1'b1;
            if (sell_q) svol_d = svol_q + {8'd0, rem};
            else        bvol_d = bvol_q + {8'd0, rem};
          end
          l_vld_d = 1'b1; phase_d = PH_FINAL; state_d = S_WAIT;
        end
      end
      S_MUL: begin
        mula_d = {24'd0, mf} * {16'd0, ma};
        mulb_d = {16'd0, fill_q} * {16'd0, p_q};
        den_d  = {1'b0, mf} + {1'b0, fill_q};
        state_d = S_DLOAD;
      end
      S_DLOAD: begin
        div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (!sel_q) begin
            navgn_d = div_quo; sel_d = 1'b1; state_d = S_MUL;
          end else begin
            navg_d  = navgn_q;
            nfill_d = nfill_q + fill_q;
            trade_d = p_q;
            if (sell_q) bvol_d = bvol_q - {8'd0, fill_q};
            else        svol_d = svol_q - {8'd0, fill_q};
            l_rec_d = '0;
            l_rec_d.op = OP_UPD;
            l_rec_d.b_en = 1'b1;
            l_rec_d.b_filled = bf_q + fill_q;
            l_rec_d.b_avg = div_quo;
            l_rec_d.n_filled = nfill_q + fill_q;
            l_rec_d.n_avg = navgn_q;
            l_idx_d = bidx_q;
            l_vld_d = 1'b1; phase_d = PH_LOOP; state_d = S_WAIT;
          end
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_oid_d = roid_q; o_st_d = rst_q; o_fq_d = rfq_q; o_av_d = rav_q;
          o_lp_d = trade_q;
          o_bb_d = tail_q.bid.v ? tail_q.bid.price : 16'd0;
          o_ba_d = tail_q.ask.v ? tail_q.ask.price : 16'd0;
          o_bv_d = bvol_q; o_sv_d = svol_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; l_vld_q <= 1'b0; out_valid_q <= 1'b0;
      next_id_q <= 32'd1; trade_q <= 16'd0; bvol_q <= 24'd0; svol_q <= 24'd0;
    end else begin
      state_q <= state_d; l_vld_q <= l_vld_d; out_valid_q <= out_valid_d;
      next_id_q <= next_id_d; trade_q <= trade_d; bvol_q <= bvol_d; svol_q <= svol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d; req_q <= req_d; sell_q <= sell_d; mkt_q <= mkt_d;
    sel_q <= sel_d; nqty_q <= nqty_d; lim_q <= lim_d; nfill_q <= nfill_d;
    key_q <= key_d; navg_q <= navg_d; navgn_q <= navgn_d;
    fill_q <= fill_d; p_q <= p_d; bf_q <= bf_d; ba_q <= ba_d; bidx_q <= bidx_d;
    mula_q <= mula_d; mulb_q <= mulb_d; den_q <= den_d;
    tail_q <= tail_d; tbidx_q <= tbidx_d; taidx_q <= taidx_d;
    roid_q <= roid_d; rst_q <= rst_d; rfq_q <= rfq_d; rav_q <= rav_d;
    l_rec_q <= l_rec_d; l_idx_q <= l_idx_d;
    o_oid_q <= o_oid_d; o_st_q <= o_st_d; o_fq_q <= o_fq_d; o_av_q <= o_av_d;
    o_lp_q <= o_lp_d; o_bb_q <= o_bb_d; o_ba_q <= o_ba_d;
    o_bv_q <= o_bv_d; o_sv_q <= o_sv_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign order_id_o   = o_oid_q;
  assign status_o     = o_st_q;
  assign filled_qty_o = o_fq_q;
  assign avg_price_o  = o_av_q;
  assign last_price_o = o_lp_q;
  assign best_bid_o   = o_bb_q;
  assign best_ask_o   = o_ba_q;
  assign bid_volume_o = o_bv_q;
  assign ask_volume_o = o_sv_q;

  // no pass may be in flight while a new request can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !state_vld_unused && !l_vld_q)
    else $error("pass in flight while idle");

  // divider completes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider result outside division state");

  // a clear pass restarts id numbering
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && c_vld[MAX_ORDERS] && req_q == REQ_CLEAR)
    |=> (next_id_q == 32'd1) && (bvol_q == 24'd0) && (svol_q == 24'd0))
    else $error("clear did not reset book totals");

endmodule
